// ----- design/spq_pkg.sv -----
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } spq_kind_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  move;
    logic [15:0] pri;
  } spq_entry_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [3:0]  move;
    logic [15:0] priority_req;
  } spq_in_t;

  typedef struct packed {
    logic              valid_res;
    logic [7:0]        out_x;
    logic [7:0]        out_y;
    logic [3:0]        out_move;
    logic [15:0]       out_priority;
    logic              duplicate;
    logic              overflow;
    logic [FILL_W-1:0] fill;
  } spq_out_t;

  typedef struct packed {
    logic       en;
    logic       pop;
    spq_entry_t ent;
  } spq_cmd_t;

  typedef struct packed {
    logic ge;
    logic eq;
  } spq_stat_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_cmd_t   cmd,
  input  logic       cell_valid,
  input  logic       left_ge,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output spq_entry_t entry,
  output spq_stat_t  stat
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  assign entry = entry_r;
  assign stat.ge = cell_valid && (entry_r.pri >= cmd.ent.pri);
  assign stat.eq = cell_valid && (entry_r == cmd.ent);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.en) begin
      if (cmd.pop) begin
        entry_nxt = right_entry;
      end else if (!stat.ge) begin
        // insertion point takes the new item, cells behind it shift back
        entry_nxt = left_ge ? cmd.ent : left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/sorted_priority_queue_unit.sv -----
// Sorted priority queue of up to DEPTH entries (x, y, action, priority), highest
// priority at the head, equal priorities served in arrival order. Each item is
// either an insert or a pop and gives exactly one result item. A row of DEPTH
// cells compares the new entry against all held entries at once and shifts
// toward or away from the head in the same edge, so one item per cycle is
// taken while the output register is free or being drained. An insert
// identical to a held entry is dropped and flagged as duplicate; an insert
// into a full queue pushes out the last entry, or is dropped if it would
// itself land last, and sets overflow. A pop on an empty queue returns
// valid_res low. fill reports the count held after the item.
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  spq_out_t         out_r;
  spq_out_t         out_nxt;

  spq_cmd_t   cmd;
  spq_entry_t entry_w [DEPTH];
  spq_stat_t  stat_w  [DEPTH];
  logic [DEPTH-1:0] eq_vec;

  logic accept;
  logic is_pop;
  logic full;
  logic empty;
  logic dup;
  logic lands_last;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_pop     = (in_data.kind == KIND_POP);
  assign full       = (occ_r == OCC_W'(DEPTH));
  assign empty      = (occ_r == '0);
  assign dup        = |eq_vec;
  assign lands_last = full && stat_w[DEPTH-1].ge;

  assign cmd.ent.x    = in_data.cell_x;
  assign cmd.ent.y    = in_data.cell_y;
  assign cmd.ent.move = in_data.move;
  assign cmd.ent.pri  = in_data.priority_req;
  assign cmd.pop      = is_pop;
  assign cmd.en       = accept && (is_pop ? !empty : !(dup || lands_last));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       left_ge;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_ge    = 1'b1;
      assign left_entry = cmd.ent;
    end else begin : g_body
      assign left_ge    = stat_w[i-1].ge;
      assign left_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entry_w[i];
    end else begin : g_mid
      assign right_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_valid (occ_r > OCC_W'(i)),
      .left_ge    (left_ge),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (entry_w[i]),
      .stat       (stat_w[i])
    );

    assign eq_vec[i] = stat_w[i].eq;
  end

  always_comb begin
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (is_pop) begin
        if (!empty) begin
          occ_nxt              = occ_r - OCC_W'(1);
          out_nxt.valid_res    = 1'b1;
          out_nxt.out_x        = entry_w[0].x;
          out_nxt.out_y        = entry_w[0].y;
          out_nxt.out_move     = entry_w[0].move;
          out_nxt.out_priority = entry_w[0].pri;
        end
      end else if (dup) begin
        out_nxt.duplicate = 1'b1;
      end else if (full) begin
        out_nxt.overflow = 1'b1;
      end else begin
        occ_nxt = occ_r + OCC_W'(1);
      end
      out_nxt.fill = FILL_W'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.duplicate && out_r.overflow))
    else $error("duplicate and overflow together");

  a_pop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.valid_res) |-> (!out_r.duplicate && !out_r.overflow))
    else $error("flags set on a pop result");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_pop && !empty) |=> (occ_r == $past(occ_r) - OCC_W'(1)))
    else $error("pop did not shrink occupancy");

  a_dup_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pop && dup) |=> $stable(occ_r))
    else $error("duplicate insert changed occupancy");

endmodule
